// ===== design/srsw_pkg.sv =====
// Shared types and constants for the selective repeat sender window.
package srsw_pkg;

    // Message and sequence number limits.
    localparam int MAX_MSG_FRAMES = 128;
    localparam int SEQ_BITS       = 3;
    localparam int SEQ_MOD        = 1 << SEQ_BITS;

    // Operation codes carried on the input channel's tuser.
    localparam logic [1:0] OP_NEW      = 2'd0;
    localparam logic [1:0] OP_ACK      = 2'd1;
    localparam logic [1:0] OP_TIMEOUT  = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // Register index decoded from paddr[2].
    localparam logic REG_WIN_CFG = 1'b0;

    // Window limits and reset value.
    localparam logic [2:0] WIN_MIN   = 3'd1;
    localparam logic [2:0] WIN_MAX   = 3'd4;
    localparam logic [2:0] WIN_RESET = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted input item
        logic update;      // apply new message or acknowledgement mark
        logic base_inc;    // step base past one acknowledged frame
        logic scan_clear;  // restart the window scan
        logic scan_step;   // examine one window slot
        logic finish;      // deliver the closing result item
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       adv_more;
        logic       scan_end;
        logic       scan_hit;
        logic       have_pend;
        logic       slot_free;
    } dp_status_t;

endpackage

// ===== design/srsw_ctrl.sv =====
// Controller state machine sequencing update, base advance and window scan.
module srsw_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  srsw_pkg::dp_status_t   status,
    output srsw_pkg::ctrl_cmd_t    cmd
);
    import srsw_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UPDATE  = 3'd1;
    localparam logic [2:0] ST_ADVANCE = 3'd2;
    localparam logic [2:0] ST_SCAN    = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update     = 1'b1;
                cmd.scan_clear = 1'b1;
                if (status.op == OP_RESERVED) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_ADVANCE;
                end
            end
            ST_ADVANCE: begin
                if (status.adv_more) begin
                    cmd.base_inc = 1'b1;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_end) begin
                    state_next = ST_FINISH;
                end else if (!(status.scan_hit && status.have_pend && !status.slot_free)) begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (status.slot_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/srsw_dpath.sv =====
// Datapath: message state, acknowledged map, window scan and output register.
module srsw_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  srsw_pkg::ctrl_cmd_t    cmd,
    output srsw_pkg::dp_status_t   status,
    input  logic [2:0]             win_cfg,
    input  logic [1:0]             in_op,
    input  logic [7:0]             in_msg_len,
    input  logic [2:0]             in_ack_seq,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_send_valid,
    output logic [6:0]             out_frame_index,
    output logic [2:0]             out_frame_seq,
    output logic                   out_message_done,
    output logic                   out_last
);
    import srsw_pkg::*;

    localparam int TW = $clog2(MAX_MSG_FRAMES + 1);
    localparam int SW = TW + 1;
    localparam int MW = ((TW > SEQ_BITS) ? TW : SEQ_BITS) + 1;
    localparam int CW = (TW > 8) ? TW : 8;

    // Latched input item.
    logic [1:0]          op_reg;
    logic [7:0]          count_reg;
    logic [2:0]          ack_reg;

    // Message state. A frame can only be marked within one sequence cycle of base,
    // so the acknowledged flags cover base through base + SEQ_MOD - 1 and are
    // indexed by the low bits of the frame position.
    logic [SEQ_MOD-1:0]  acked_reg;
    logic [TW-1:0]       base_reg;
    logic [TW-1:0]       total_reg;
    logic [SEQ_BITS-1:0] first_seq_reg;
    logic [SEQ_BITS-1:0] seq_next_reg;

    // Window scan.
    logic [2:0]          k_reg;
    logic                have_pend_reg;
    logic [6:0]          pend_index_reg;
    logic [2:0]          pend_seq_reg;

    // Output register.
    logic                out_valid_reg;
    logic                out_send_valid_reg;
    logic [6:0]          out_index_reg;
    logic [2:0]          out_seq_reg;
    logic                out_done_reg;
    logic                out_last_reg;

    logic [2:0]          win_eff;
    logic                done;
    logic                slot_free;
    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       cnt_sat;
    logic [SEQ_BITS-1:0] seq_sum;
    logic [SEQ_BITS+2:0] ack_wide;
    logic [SEQ_BITS+TW-1:0] base_wide;
    logic [SEQ_BITS-1:0] ack_d;
    logic [MW-1:0]       mark_idx;
    logic                mark_ok;
    logic [SW-1:0]       scan_idx;
    logic                scan_in_range;
    logic                scan_hit;
    logic [MW-1:0]       cand_seq_sum;
    logic [SEQ_BITS+2:0] cand_seq_wide;
    logic [SW+6:0]       cand_idx_wide;
    logic                push_pend;
    logic                push_final;

    // Effective window: zero acts as one, above four acts as four.
    always_comb begin
        priority if (win_cfg < WIN_MIN) begin
            win_eff = WIN_MIN;
        end else if (win_cfg > WIN_MAX) begin
            win_eff = WIN_MAX;
        end else begin
            win_eff = win_cfg;
        end
    end

    assign done      = (base_reg >= total_reg);
    assign slot_free = !out_valid_reg || out_ready;

    // New message: saturate the count and continue the sequence counter.
    assign cnt_ext = CW'(count_reg);
    assign cnt_sat = (cnt_ext > CW'(MAX_MSG_FRAMES)) ? CW'(MAX_MSG_FRAMES) : cnt_ext;
    assign seq_sum = seq_next_reg + cnt_sat[SEQ_BITS-1:0];

    // Acknowledgement: the only candidate at or after base is base plus the sequence offset.
    assign ack_wide  = {{SEQ_BITS{1'b0}}, ack_reg};
    assign base_wide = {{SEQ_BITS{1'b0}}, base_reg};
    assign ack_d     = ack_wide[SEQ_BITS-1:0] - first_seq_reg - base_wide[SEQ_BITS-1:0];
    assign mark_idx  = MW'(base_reg) + MW'(ack_d);
    assign mark_ok   = (mark_idx < MW'(total_reg));

    // Window slot under examination.
    assign scan_idx      = SW'(base_reg) + SW'(k_reg);
    assign scan_in_range = (scan_idx < SW'(total_reg));
    assign scan_hit      = scan_in_range && !acked_reg[scan_idx[SEQ_BITS-1:0]];
    assign cand_seq_sum  = MW'(first_seq_reg) + MW'(scan_idx);
    assign cand_seq_wide = {3'b000, cand_seq_sum[SEQ_BITS-1:0]};
    assign cand_idx_wide = {7'b0000000, scan_idx};

    assign push_pend  = cmd.scan_step && scan_hit && have_pend_reg;
    assign push_final = cmd.finish;

    // Status back to the controller.
    always_comb begin
        status.op        = op_reg;
        status.adv_more  = (base_reg < total_reg) && acked_reg[base_reg[SEQ_BITS-1:0]];
        status.scan_end  = (k_reg == win_eff) || !scan_in_range;
        status.scan_hit  = scan_hit;
        status.have_pend = have_pend_reg;
        status.slot_free = slot_free;
    end

    // Input item latch.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_op;
            count_reg <= in_msg_len;
            ack_reg   <= in_ack_seq;
        end
    end

    // Message state: new message, acknowledgement mark and base advance.
    // Stepping base frees the flag of the passed frame for the frame SEQ_MOD positions later.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acked_reg     <= '0;
            base_reg      <= '0;
            total_reg     <= '0;
            first_seq_reg <= '0;
            seq_next_reg  <= '0;
        end else begin
            if (cmd.update && op_reg == OP_NEW && count_reg != 8'd0) begin
                first_seq_reg <= seq_next_reg;
                seq_next_reg  <= seq_sum;
                total_reg     <= cnt_sat[TW-1:0];
                acked_reg     <= '0;
                base_reg      <= '0;
            end else if (cmd.update && op_reg == OP_ACK && mark_ok) begin
                acked_reg[mark_idx[SEQ_BITS-1:0]] <= 1'b1;
            end else if (cmd.base_inc) begin
                base_reg                          <= base_reg + TW'(1);
                acked_reg[base_reg[SEQ_BITS-1:0]] <= 1'b0;
            end
        end
    end

    // Window scan: hold one found frame back so the final one can carry last.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= '0;
            have_pend_reg <= 1'b0;
        end else begin
            if (cmd.scan_clear || cmd.finish) begin
                k_reg         <= '0;
                have_pend_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                k_reg <= k_reg + 3'd1;
                if (scan_hit) begin
                    have_pend_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && scan_hit) begin
            pend_index_reg <= cand_idx_wide[6:0];
            pend_seq_reg   <= cand_seq_wide[2:0];
        end
    end

    // Output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (push_pend || push_final) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload: a held frame, or the closing item with the last held frame or the empty result.
    always_ff @(posedge aclk) begin
        if (push_pend) begin
            out_send_valid_reg <= 1'b1;
            out_index_reg      <= pend_index_reg;
            out_seq_reg        <= pend_seq_reg;
            out_done_reg       <= done;
            out_last_reg       <= 1'b0;
        end else if (push_final) begin
            out_send_valid_reg <= have_pend_reg;
            out_index_reg      <= have_pend_reg ? pend_index_reg : 7'd0;
            out_seq_reg        <= have_pend_reg ? pend_seq_reg : 3'd0;
            out_done_reg       <= done;
            out_last_reg       <= 1'b1;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_send_valid   = out_send_valid_reg;
    assign out_frame_index  = out_index_reg;
    assign out_frame_seq    = out_seq_reg;
    assign out_message_done = out_done_reg;
    assign out_last         = out_last_reg;

endmodule

// ===== design/selective_repeat_sender_window.sv =====
// Steps per item: update, base advance past each acknowledged frame at base, window scan
// of up to four slots and the closing item; a reserved op skips advance and scan.
// The next item is taken only once this one's closing item is in the output register.
// Result items wait in one output register; the scan and the closing step stall only while
// it holds an item that has not been taken.
// Reset (aresetn low, synchronous) clears the acknowledged flags, base, frame count and
// sequence counter and sets the window register to 4; no clearing pass.
module selective_repeat_sender_window (
    input  logic        aclk,
    input  logic        aresetn,
    // Input item channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // msg_len[7:0], ack_seq[10:8], zero fill
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // Result item channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // frame_index[6:0], frame_seq[9:7],
                                        // message_done[10], zero fill
    output logic [0:0]  m_axis_tuser,   // send_valid[0]
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import srsw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic [2:0] win_cfg_reg;
    logic       send_valid;
    logic [6:0] frame_index;
    logic [2:0] frame_seq;
    logic       message_done;

    // Configuration register.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg <= WIN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_WIN_CFG) begin
            win_cfg_reg <= pwdata[2:0];
        end
    end

    assign prdata = (paddr[2] == REG_WIN_CFG) ? {29'd0, win_cfg_reg} : 32'd0;

    srsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    srsw_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .win_cfg          (win_cfg_reg),
        .in_op            (s_axis_tuser),
        .in_msg_len       (s_axis_tdata[7:0]),
        .in_ack_seq       (s_axis_tdata[10:8]),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_send_valid   (send_valid),
        .out_frame_index  (frame_index),
        .out_frame_seq    (frame_seq),
        .out_message_done (message_done),
        .out_last         (m_axis_tlast)
    );

    // Result packing.
    assign m_axis_tdata = {5'd0, message_done, frame_seq, frame_index};
    assign m_axis_tuser = send_valid;

endmodule
